// ===== src/givens_rotation_unit_defines.svh =====
// Assertion macros used by the checker module gru_checker.
`ifndef GIVENS_ROTATION_UNIT_DEFINES_SVH
`define GIVENS_ROTATION_UNIT_DEFINES_SVH
// Checks that an antecedent implies a consequent in the next cycle.
`define GRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Checks that an antecedent implies a consequent in the same cycle.
`define GRU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ===== src/gru_pkg.sv =====
`default_nettype none
package gru_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS = 30;
    localparam logic [COEF_WIDTH-1:0] COEF_ONE = 32'h4000_0000;
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_APPLY = 1'b1;
    // Iterative stages: 31 quotient bits, 31 root bits, 31 reciprocal bits.
    localparam int DIV_STEPS = 31;
    localparam int SQRT_STEPS = 31;
    localparam int RCP_STEPS = 31;
    localparam int APP_STAGES = 2;
    localparam int LATENCY = 1 + DIV_STEPS + 1 + SQRT_STEPS + RCP_STEPS + 2;
endpackage
`default_nettype wire

// ===== src/gru_cell.sv =====
`default_nettype none
// One step of a restoring division or square root: a shared cell kind.
// MODE 0: divide step, MODE 1: square root step.
module gru_cell #(
    parameter int W = 64,
    parameter int MODE = 0,
    parameter int POS = 0
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_rem,
    input  wire logic [W-1:0] i_den,
    input  wire logic [W-1:0] i_acc,
    output logic      [W-1:0] o_rem,
    output logic      [W-1:0] o_acc
);
    logic [W-1:0] n_rem, n_acc, r_rem, r_acc, w_trial;
    always_comb begin
        n_rem = i_rem;
        n_acc = i_acc;
        if (MODE == 0) begin
            // i_acc holds the quotient; the remainder is shifted each step.
            if (i_rem >= i_den) begin
                n_rem = i_rem - i_den;
                n_acc = i_acc | (W'(1) << POS);
            end
            n_rem = n_rem << 1;
            w_trial = '0;
        end else begin
            // Bit-by-bit root: i_acc is the partial root shifted as in the model.
            w_trial = i_acc + (W'(1) << (2 * POS));
            if (i_rem >= w_trial) begin
                n_rem = i_rem - w_trial;
                n_acc = (i_acc >> 1) + (W'(1) << (2 * POS));
            end else begin
                n_acc = i_acc >> 1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_acc <= n_acc;
    end
    assign o_rem = r_rem;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// ===== src/gru_generate.sv =====
`default_nettype none
// Generate path: ratio, root and reciprocal, each a chain of step cells.
module gru_generate #(
    parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    output logic      [31:0]           o_cos,
    output logic      [31:0]           o_sin
);
    localparam int W = 64;
    localparam int ND = gru_pkg::DIV_STEPS;
    localparam int NS = gru_pkg::SQRT_STEPS;
    localparam int NR = gru_pkg::RCP_STEPS;
    localparam int NT = ND + 1 + NS + NR;
    // Per-item side information carried along the chain.
    typedef struct packed {
        logic zero_b;
        logic b_larger;
        logic neg;
        logic [31:0] t;
    } t_side;

    logic [DATA_WIDTH-1:0] w_ma, w_mb;
    logic                  w_bl;
    logic [NT:0][W-1:0]    w_rem, w_acc, w_den;
    t_side [NT:0]          r_side;

    assign w_ma = i_a[DATA_WIDTH-1] ? DATA_WIDTH'(-i_a) : i_a;
    assign w_mb = i_b[DATA_WIDTH-1] ? DATA_WIDTH'(-i_b) : i_b;
    assign w_bl = w_mb > w_ma;

    always_ff @(posedge i_clk) begin
        r_side[0].zero_b <= (i_b == '0);
        r_side[0].b_larger <= w_bl;
        r_side[0].neg <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
        r_side[0].t <= '0;
        for (int k = 1; k <= NT; k++) begin
            // The ratio joins the side data once the divide chain has finished.
            if (k == ND + 1) begin
                r_side[k] <= {r_side[k-1].zero_b, r_side[k-1].b_larger, r_side[k-1].neg,
                              32'(w_acc[ND])};
            end else begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [W-1:0] r_num, r_den0;
    always_ff @(posedge i_clk) begin
        r_num <= W'(w_bl ? w_ma : w_mb);
        r_den0 <= (i_b == '0) ? W'(1) : W'(w_bl ? w_mb : w_ma);
    end
    assign w_rem[0] = r_num;
    assign w_acc[0] = '0;
    assign w_den[0] = r_den0;

    // Denominator travels with the item.
    logic [ND-1:0][W-1:0] r_dpipe;
    genvar g;
    generate
        for (g = 0; g < ND; g++) begin : g_div
            gru_cell #(.W(W), .MODE(0), .POS(30 - g)) u_cell (
                .i_clk(i_clk), .i_rem(w_rem[g]), .i_den(w_den[g]),
                .i_acc(w_acc[g]), .o_rem(w_rem[g+1]), .o_acc(w_acc[g+1]));
            always_ff @(posedge i_clk) r_dpipe[g] <= w_den[g];
            assign w_den[g+1] = r_dpipe[g];
        end
    endgenerate

    // t*t in one 32x32 product, registered.
    logic [W-1:0] r_x;
    always_ff @(posedge i_clk) begin
        r_x <= (W'(1) << 60) + W'(w_acc[ND][31:0]) * W'(w_acc[ND][31:0]);
    end
    assign w_rem[ND+1] = r_x;
    assign w_acc[ND+1] = '0;
    assign w_den[ND+1] = '0;
    // x is at least 2^60, so the first root bit is 2^60.
    generate
        for (g = 0; g < NS; g++) begin : g_sqrt
            gru_cell #(.W(W), .MODE(1), .POS(30 - g)) u_cell (
                .i_clk(i_clk), .i_rem(w_rem[ND+1+g]), .i_den('0),
                .i_acc(w_acc[ND+1+g]), .o_rem(w_rem[ND+2+g]), .o_acc(w_acc[ND+2+g]));
            assign w_den[ND+2+g] = '0;
        end
    endgenerate

    // Reciprocal 2^60 / s: quotient has 31 bits (r <= 2^30).
    localparam int B0 = ND + 1 + NS;
    logic [NR-1:0][W-1:0] r_spipe;
    logic [NR:0][W-1:0]   w_rrem, w_racc, w_rden;
    assign w_rrem[0] = W'(1) << 30;
    assign w_racc[0] = '0;
    assign w_rden[0] = w_acc[B0];
    generate
        for (g = 0; g < NR; g++) begin : g_rcp
            gru_cell #(.W(W), .MODE(0), .POS(30 - g)) u_cell (
                .i_clk(i_clk), .i_rem(w_rrem[g]), .i_den(w_rden[g]),
                .i_acc(w_racc[g]), .o_rem(w_rrem[g+1]), .o_acc(w_racc[g+1]));
            always_ff @(posedge i_clk) r_spipe[g] <= w_rden[g];
            assign w_rden[g+1] = r_spipe[g];
        end
    endgenerate
    // Unused chain slots past the root stage.
    generate
        for (g = B0 + 1; g <= NT; g++) begin : g_tie
            assign w_rem[g] = '0;
            assign w_acc[g] = '0;
            assign w_den[g] = '0;
        end
    endgenerate

    // Final product and sign fix, two register stages.
    logic [31:0] r_r, r_o;
    t_side       r_s1;
    always_ff @(posedge i_clk) begin
        r_s1 <= r_side[NT];
        r_r  <= 32'(w_racc[NR]);
        r_o  <= 32'((W'(r_side[NT].t) * W'(w_racc[NR][31:0])) >> 30);
        if (r_s1.zero_b) begin
            o_cos <= gru_pkg::COEF_ONE;
            o_sin <= '0;
        end else if (r_s1.b_larger) begin
            o_sin <= r_r;
            o_cos <= r_s1.neg ? -r_o : r_o;
        end else begin
            o_cos <= r_r;
            o_sin <= r_s1.neg ? -r_o : r_o;
        end
    end
endmodule
`default_nettype wire

// ===== src/gru_apply.sv =====
`default_nettype none
// Apply path: clamp, four products, sum, floor shift, saturate.
module gru_apply #(
    parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic [DATA_WIDTH-1:0] i_a,
    input  wire logic [DATA_WIDTH-1:0] i_b,
    input  wire logic [31:0]           i_c,
    input  wire logic [31:0]           i_s,
    output logic      [DATA_WIDTH-1:0] o_r1,
    output logic      [DATA_WIDTH-1:0] o_r2
);
    localparam int PW = DATA_WIDTH + 32;
    localparam int SW = PW + 2;
    logic signed [31:0] w_c, w_s;
    logic signed [PW-1:0] r_ca, r_sb, r_sa, r_cb;
    logic signed [SW-1:0] w_d1, w_d2, w_q1, w_q2;
    localparam logic signed [SW-1:0] MAXV = SW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    function automatic logic signed [31:0] clamp(input logic signed [31:0] v);
        if (v > $signed(gru_pkg::COEF_ONE)) return $signed(gru_pkg::COEF_ONE);
        if (v < -$signed(gru_pkg::COEF_ONE)) return -$signed(gru_pkg::COEF_ONE);
        return v;
    endfunction

    assign w_c = clamp($signed(i_c));
    assign w_s = clamp($signed(i_s));
    always_ff @(posedge i_clk) begin
        r_ca <= PW'(w_c) * PW'($signed(i_a));
        r_sb <= PW'(w_s) * PW'($signed(i_b));
        r_sa <= PW'(w_s) * PW'($signed(i_a));
        r_cb <= PW'(w_c) * PW'($signed(i_b));
    end
    assign w_d1 = SW'(r_ca) - SW'(r_sb);
    assign w_d2 = SW'(r_sa) + SW'(r_cb);
    assign w_q1 = w_d1 >>> gru_pkg::FRAC_BITS;
    assign w_q2 = w_d2 >>> gru_pkg::FRAC_BITS;
    always_ff @(posedge i_clk) begin
        o_r1 <= (w_q1 > MAXV) ? DATA_WIDTH'(MAXV) :
                (w_q1 < MINV) ? DATA_WIDTH'(MINV) : DATA_WIDTH'(w_q1);
        o_r2 <= (w_q2 > MAXV) ? DATA_WIDTH'(MAXV) :
                (w_q2 < MINV) ? DATA_WIDTH'(MINV) : DATA_WIDTH'(w_q2);
    end
endmodule
`default_nettype wire

// ===== src/givens_rotation_unit.sv =====
// An input word reaches m_axis through the cell chains, then the result FIFO write, its
// registered RAM read and the output stage.
// Throughput: one word per cycle unless out of credits; cell chains set the latency.
// The chain never stalls: a credit-counted result FIFO absorbs back-pressure, and
// s_axis_tready drops only when every credit is in use.
// Reset (i_rst_n low, synchronous) empties the valid pipeline; data registers are not reset.
`default_nettype none
module givens_rotation_unit #(
    parameter int DATA_WIDTH = gru_pkg::DATA_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // operation, first_value, second_value, cos_in, sin_in from bit 0 up, zero padded
    input  wire logic [((1 + 2 * DATA_WIDTH + 64 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // cos_out, sin_out, rotated_first, rotated_second from bit 0 up, zero padded
    output logic [((64 + 2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    localparam int LAT = gru_pkg::LATENCY;
    localparam int OW = ((64 + 2 * DATA_WIDTH + 7) / 8) * 8;
    // The pipeline has no stall; a result FIFO deep enough for all items in
    // flight absorbs back-pressure, and the input is throttled by the credit count.
    // A word holds its credit from acceptance until m_axis takes it, and FD = LAT + 4
    // credits keep the input open every cycle while the output is never held off.
    localparam int FD = LAT + 4;
    localparam int AW = $clog2(FD + 1);

    logic w_in_acc;
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_op;
    logic [31:0] w_cos, w_sin;
    logic [DATA_WIDTH-1:0] w_a, w_b, w_r1, w_r2;
    logic [AW-1:0] r_cnt, n_cnt;

    assign w_a = s_axis_tdata[1 +: DATA_WIDTH];
    assign w_b = s_axis_tdata[1 + DATA_WIDTH +: DATA_WIDTH];
    // Credits: items in flight plus items held in the result FIFO and output stage.
    assign s_axis_tready = (r_cnt < AW'(FD));
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    gru_generate #(.DATA_WIDTH(DATA_WIDTH)) u_gen (
        .i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_cos(w_cos), .o_sin(w_sin));

    // The apply path is short; its result is delayed to line up with generate.
    logic [DATA_WIDTH-1:0] w_ar1, w_ar2;
    gru_apply #(.DATA_WIDTH(DATA_WIDTH)) u_app (
        .i_clk(i_clk), .i_a(w_a), .i_b(w_b),
        .i_c(s_axis_tdata[1 + 2 * DATA_WIDTH +: 32]),
        .i_s(s_axis_tdata[33 + 2 * DATA_WIDTH +: 32]),
        .o_r1(w_ar1), .o_r2(w_ar2));
    localparam int DL = LAT - gru_pkg::APP_STAGES;
    logic [DL-1:0][DATA_WIDTH-1:0] r_d1, r_d2;
    always_ff @(posedge i_clk) begin
        r_d1[0] <= w_ar1;
        r_d2[0] <= w_ar2;
        for (int k = 1; k < DL; k++) begin
            r_d1[k] <= r_d1[k-1];
            r_d2[k] <= r_d2[k-1];
        end
    end
    assign w_r1 = r_d1[DL-1];
    assign w_r2 = r_d2[DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_in_acc};
        end
        r_op <= {r_op[LAT-2:0], s_axis_tdata[0]};
    end

    // Result word assembled at the chain end.
    logic [OW-1:0] w_word;
    always_comb begin
        w_word = '0;
        if (r_op[LAT-1] == gru_pkg::OP_GENERATE) begin
            w_word[31:0] = w_cos;
            w_word[63:32] = w_sin;
        end else begin
            w_word[64 +: DATA_WIDTH] = w_r1;
            w_word[64 + DATA_WIDTH +: DATA_WIDTH] = w_r2;
        end
    end

    // Result FIFO; memory is the generic RAM with registered read.
    localparam int FA = $clog2(FD);
    logic [FA-1:0] r_wp, r_rp;
    logic [AW-1:0] r_fcnt;
    logic w_push, w_pop, r_rdv, w_rd;
    logic [OW-1:0] w_q, r_hold, n_hold, r_skid, n_skid;
    logic r_hv, n_hv, r_sv, n_sv;
    logic [1:0] w_occ;
    assign w_push = r_vld[LAT-1];
    // Output stage: r_hold holds the word shown on m_axis, r_skid catches a word
    // already read from the RAM when the output is held off.
    assign w_pop = m_axis_tvalid && m_axis_tready;
    // Words in the output stage or on their way out of the RAM after this cycle.
    assign w_occ = 2'(r_hv) + 2'(r_sv) + 2'(r_rdv) - 2'(w_pop);
    assign w_rd = (r_fcnt != '0) && (w_occ < 2'd2);
    gru_ram #(.WIDTH(OW), .DEPTH(FD)) u_ram (
        .i_clk(i_clk), .i_we(w_push), .i_waddr(r_wp), .i_wdata(w_word),
        .i_raddr(r_rp), .o_rdata(w_q));

    always_comb begin
        n_cnt = r_cnt;
        if (w_in_acc && !w_pop) n_cnt = r_cnt + AW'(1);
        if (!w_in_acc && w_pop) n_cnt = r_cnt - AW'(1);
    end

    always_comb begin
        n_hv = r_hv;
        n_sv = r_sv;
        n_hold = r_hold;
        n_skid = r_skid;
        if (w_pop) begin
            n_hv = r_sv;
            n_hold = r_skid;
            n_sv = 1'b0;
        end
        if (r_rdv) begin
            if (!n_hv) begin
                n_hv = 1'b1;
                n_hold = w_q;
            end else begin
                n_sv = 1'b1;
                n_skid = w_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp <= '0;
            r_rp <= '0;
            r_fcnt <= '0;
            r_rdv <= 1'b0;
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= (r_wp == FA'(FD - 1)) ? '0 : r_wp + FA'(1);
            if (w_rd) r_rp <= (r_rp == FA'(FD - 1)) ? '0 : r_rp + FA'(1);
            r_fcnt <= r_fcnt + AW'(w_push) - AW'(w_rd);
            r_rdv <= w_rd;
            r_hv <= n_hv;
            r_sv <= n_sv;
        end
        r_hold <= n_hold;
        r_skid <= n_skid;
    end
    assign m_axis_tvalid = r_hv;
    assign m_axis_tdata = r_hold;
endmodule
`default_nettype wire

// ===== src/gru_ram.sv =====
`default_nettype none
module gru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/gru_checker.sv =====
`default_nettype none
`include "givens_rotation_unit_defines.svh"
module gru_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready
);
    // A word shown and not taken stays shown.
    `GRU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped")
    // Output valid is low in the cycle after any cycle with reset low.
    `GRU_ASSERT_NEXT(a_rst, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    // A rising output valid needs i_rst_n high in the earlier sample that $past(i_rst_n, 2) reads.
    `GRU_ASSERT_NOW(a_early, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(i_rst_n, 2), "result too soon after reset")
endmodule
bind givens_rotation_unit gru_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready));
`default_nettype wire

// ===== test/givens_rotation_unit_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module givens_rotation_unit_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    input  wire logic [DATA_WIDTH*2+64:0] i_in_word,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic [DATA_WIDTH*2+63:0] i_out_word,
    output int                          o_errors,
    output int                          o_pending
);
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] rot_second;
        logic signed [DATA_WIDTH-1:0] rot_first;
        logic signed [31:0]           sine;
        logic signed [31:0]           cosine;
    } t_rotation_result;

    t_rotation_result rotation_queue[$];

    function automatic logic signed [63:0] floor_q30(input logic signed [127:0] v);
        return 64'(v >>> gru_pkg::FRAC_BITS);
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] clamp_unit(input logic signed [31:0] c);
        logic signed [63:0] w;
        w = c;
        if (w > 64'sd1073741824) return 64'sd1073741824;
        if (w < -64'sd1073741824) return -64'sd1073741824;
        return w;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[DATA_WIDTH-1:0];
        if (v < lo) return lo[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

    // Works out the rotation result for one input word.
    function automatic t_rotation_result rotate_word(input logic [DATA_WIDTH*2+64:0] w);
        t_rotation_result res;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] c;
        logic signed [63:0] s;
        logic [63:0] ma, mb, num, den, t, root, r, o;
        logic b_larger, neg;
        a = $signed(w[DATA_WIDTH:1]);
        b = $signed(w[2*DATA_WIDTH:DATA_WIDTH+1]);
        res = '0;
        if (w[0] == gru_pkg::OP_GENERATE) begin
            if (b == 0) begin
                res.cosine = gru_pkg::COEF_ONE;
            end else begin
                ma = a < 0 ? -a : a;
                mb = b < 0 ? -b : b;
                b_larger = mb > ma;
                num = b_larger ? ma : mb;
                den = b_larger ? mb : ma;
                neg = (a < 0) != (b < 0);
                t = (num << gru_pkg::FRAC_BITS) / den;
                root = isqrt64((64'd1 << 60) + t * t);
                r = (64'd1 << 60) / root;
                o = (t * r) >> gru_pkg::FRAC_BITS;
                if (neg) o = -o;
                if (b_larger) begin
                    res.sine = r[31:0];
                    res.cosine = o[31:0];
                end else begin
                    res.cosine = r[31:0];
                    res.sine = o[31:0];
                end
            end
        end else begin
            c = clamp_unit(w[2*DATA_WIDTH+32:2*DATA_WIDTH+1]);
            s = clamp_unit(w[2*DATA_WIDTH+64:2*DATA_WIDTH+33]);
            res.rot_first = sat_data(floor_q30(128'(c) * 128'(a) - 128'(s) * 128'(b)));
            res.rot_second = sat_data(floor_q30(128'(s) * 128'(a) + 128'(c) * 128'(b)));
        end
        return res;
    endfunction

    assign o_pending = rotation_queue.size();

    always @(posedge i_clk) begin
        t_rotation_result want;
        t_rotation_result got;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) rotation_queue.push_back(rotate_word(i_in_word));
            if (i_out_valid && i_out_ready) begin
                got = i_out_word;
                if (rotation_queue.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rotation_queue.pop_front();
                    if (want.cosine !== got.cosine || want.sine !== got.sine ||
                        want.rot_first !== got.rot_first ||
                        want.rot_second !== got.rot_second) begin
                        $display("%0t: expected cos %h sin %h r1 %h r2 %h, got %h %h %h %h",
                                 $time, want.cosine, want.sine, want.rot_first,
                                 want.rot_second, got.cosine, got.sine, got.rot_first,
                                 got.rot_second);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== test/givens_rotation_unit_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module givens_rotation_unit_tb;
    localparam int DW = 32;
    localparam int IN_BITS = ((1 + 2 * DW + 64 + 7) / 8) * 8;
    localparam int OUT_BITS = ((64 + 2 * DW + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 1130;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // operation, first_value, second_value, cos_in, sin_in from bit 0 up, zero padded
    logic [IN_BITS-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // cos_out, sin_out, rotated_first, rotated_second from bit 0 up, zero padded
    logic [OUT_BITS-1:0] m_axis_tdata;
    int errors;
    int pending;
    int cycles = 0;
    int rx_wait = 0;

    always #5 i_clk = ~i_clk;

    givens_rotation_unit #(.DATA_WIDTH(DW)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    givens_rotation_unit_checker #(.DATA_WIDTH(DW)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_word(s_axis_tdata[2*DW+64:0]),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_word(m_axis_tdata[2*DW+63:0]),
        .o_errors(errors), .o_pending(pending)
    );

    // Picks a data value, biased towards the edges and zero where the awkward cases live.
    function automatic logic [DW-1:0] pick_data();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return {1'b0, {(DW-1){1'b1}}};
            2: return {1'b1, {(DW-1){1'b0}}};
            3: return DW'($signed($urandom_range(0, 200)) - 100);
            default: return DW'($urandom());
        endcase
    endfunction

    // Coefficients are mostly in range, with the odd out-of-range word to exercise clamping.
    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 32'h4000_0000;
            1: return 32'hC000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    // Presents one word after the given gap and holds it until the block takes it.
    // With no gap, tvalid simply stays high into the next word.
    task automatic send_word(input logic op, input logic [DW-1:0] a, input logic [DW-1:0] b,
                             input logic [31:0] c, input logic [31:0] s, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_BITS'({s, c, b, a, op});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // After each taken word the receiver draws a wait with tready low, half the time none.
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_axis_tready) begin
            if (m_axis_tvalid) begin
                draw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
                if (draw != 0) begin
                    m_axis_tready <= 1'b0;
                    rx_wait <= draw;
                end
            end
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int gap;
        logic op;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed words: zero second value, zero first value, equal magnitudes, extremes,
        // clamped coefficients and saturating rotations.
        send_word(gru_pkg::OP_GENERATE, 32'h0001_0000, '0, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, '0, '0, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, '0, 32'hFFFF_0000, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, 32'h0003_0000, 32'hFFFD_0000, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, 32'h8000_0000, 32'h8000_0000, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 1);
        send_word(gru_pkg::OP_GENERATE, 32'h0000_0001, 32'h7FFF_FFFF, '0, '0, 0);
        send_word(gru_pkg::OP_GENERATE, 32'h8000_0000, 32'h0000_0001, '0, '0, 2);
        send_word(gru_pkg::OP_APPLY, 32'h0001_0000, 32'h0002_0000, 32'h4000_0000, '0, 0);
        send_word(gru_pkg::OP_APPLY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h4000_0000,
                  32'hC000_0000, 0);
        send_word(gru_pkg::OP_APPLY, 32'h8000_0000, 32'h8000_0000, 32'h4000_0000,
                  32'h4000_0000, 0);
        send_word(gru_pkg::OP_APPLY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 0);
        send_word(gru_pkg::OP_APPLY, 32'hFFFF_FFFF, 32'h0000_0001, 32'h2D41_3CCD,
                  32'h2D41_3CCD, 0);
        send_word(gru_pkg::OP_APPLY, 32'h1234_5678, 32'hFEDC_BA98, 32'hFFFF_FFFF,
                  32'hC000_0000, 3);
        s_axis_tvalid <= 1'b0;
        // Hold off until the pipeline has drained completely.
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Bursts of back-to-back words alternate with gappy stretches.
            gap = ((n / 100) % 2 == 0) ? 0 : $urandom_range(0, 19);
            op = 1'($urandom_range(0, 1));
            send_word(op, pick_data(), pick_data(), pick_coef(), pick_coef(), gap);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (gru_pkg::LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
